### rtl/swrc_pkg.sv
// Shared constants, types and command/status structs for the replay window check.
package swrc_pkg;

   localparam int WINDOW_BITS = 64;
   localparam int WIN_IDX_W   = $clog2(WINDOW_BITS);
   localparam int SEQ_W       = 32;
   localparam int CNT_W       = 32;
   localparam int SUM_W       = CNT_W + 1;
   localparam int QUAL_W      = 7;
   localparam int PROD_W      = CNT_W + QUAL_W + 1;
   localparam int PCT_SCALE   = 100;
   localparam int DIV_STEPS   = QUAL_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   localparam logic STATUS_ACCEPT = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // Controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_PREP  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_LOAD  = 5'b10000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic check;
      logic start_div;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic div_last;
   } sts_type;

endpackage

### rtl/swrc_if.sv
// Valid/ready channel interfaces for the request and response beats.
interface swrc_req_if;
   import swrc_pkg::*;
   logic             valid;
   logic             ready;
   logic [SEQ_W-1:0] sequence_req;
   modport source (output valid, output sequence_req, input ready);
   modport sink   (input valid, input sequence_req, output ready);
endinterface

interface swrc_rsp_if;
   import swrc_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic [CNT_W-1:0]  accepted_count;
   logic [CNT_W-1:0]  rejected_count;
   logic [QUAL_W-1:0] accept_pct;
   modport source (output valid, output status, output accepted_count,
                   output rejected_count, output accept_pct, input ready);
   modport sink   (input valid, input status, input accepted_count,
                   input rejected_count, input accept_pct, output ready);
endinterface

### rtl/swrc_datapath.sv
// Datapath: window check, counters, serial link-quality divider, output register.
module swrc_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  swrc_pkg::cmd_type         cmd,
   output swrc_pkg::sts_type         sts,
   input  logic [swrc_pkg::SEQ_W-1:0]  seq_in,
   output logic                      status_out,
   output logic [swrc_pkg::CNT_W-1:0]  accepted_out,
   output logic [swrc_pkg::CNT_W-1:0]  rejected_out,
   output logic [swrc_pkg::QUAL_W-1:0] quality_out
);
   import swrc_pkg::*;

   logic                   seeded_ff, seeded_in;
   logic [SEQ_W-1:0]       highest_ff, highest_in;
   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic [CNT_W-1:0]       accepted_ff, accepted_in;
   logic [CNT_W-1:0]       rejected_ff, rejected_in;
   logic [SEQ_W-1:0]       seq_ff;
   logic                   status_ff, status_in;
   logic [PROD_W-1:0]      rem_ff, rem_in;
   logic [SUM_W-1:0]       den_ff;
   logic [QUAL_W-1:0]      quot_ff, quot_in;
   logic [STEP_W-1:0]      step_ff;
   logic                   out_status_ff;
   logic [CNT_W-1:0]       out_accepted_ff, out_rejected_ff;
   logic [QUAL_W-1:0]      out_quality_ff;

   logic [SEQ_W-1:0]  diff;
   logic [SEQ_W-1:0]  back;
   logic              older;
   logic              ok;
   logic [PROD_W-1:0] den_shift;

   // Window check and update
   always_comb begin
      diff        = seq_ff - highest_ff;
      back        = SEQ_W'(0) - diff;
      older       = (diff == '0) || diff[SEQ_W-1];
      seeded_in   = seeded_ff;
      highest_in  = highest_ff;
      window_in   = window_ff;
      ok          = 1'b1;
      if (!seeded_ff) begin
         seeded_in  = 1'b1;
         highest_in = seq_ff;
         window_in  = WINDOW_BITS'(1);
      end else if (older) begin
         if (back >= SEQ_W'(WINDOW_BITS)) begin
            ok = 1'b0;
         end else if (window_ff[back[WIN_IDX_W-1:0]]) begin
            ok = 1'b0;
         end else begin
            window_in[back[WIN_IDX_W-1:0]] = 1'b1;
         end
      end else begin
         if (diff >= SEQ_W'(WINDOW_BITS)) begin
            window_in = WINDOW_BITS'(1);
         end else begin
            window_in = (window_ff << diff[WIN_IDX_W-1:0]) | WINDOW_BITS'(1);
         end
         highest_in = seq_ff;
      end
      accepted_in = ok ? accepted_ff + CNT_W'(1) : accepted_ff;
      rejected_in = ok ? rejected_ff : rejected_ff + CNT_W'(1);
      status_in   = ok ? STATUS_ACCEPT : STATUS_REJECT;
   end

   // One restoring step per cycle, quotient bit MSB first
   always_comb begin
      den_shift = PROD_W'(den_ff) << step_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      if (rem_ff >= den_shift) begin
         rem_in          = rem_ff - den_shift;
         quot_in[step_ff] = 1'b1;
      end
   end

   assign sts.div_last = (step_ff == '0);

   // Window state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff   <= 1'b0;
         highest_ff  <= '0;
         window_ff   <= '0;
         accepted_ff <= '0;
         rejected_ff <= '0;
      end else if (cmd.check) begin
         seeded_ff   <= seeded_in;
         highest_ff  <= highest_in;
         window_ff   <= window_in;
         accepted_ff <= accepted_in;
         rejected_ff <= rejected_in;
      end
   end

   // Item payload, divider and output register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff <= seq_in;
      end
      if (cmd.check) begin
         status_ff <= status_in;
      end
      if (cmd.start_div) begin
         rem_ff  <= PROD_W'(accepted_ff) * PROD_W'(PCT_SCALE);
         den_ff  <= SUM_W'(accepted_ff) + SUM_W'(rejected_ff);
         quot_ff <= '0;
         step_ff <= STEP_W'(DIV_STEPS - 1);
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         step_ff <= step_ff - STEP_W'(1);
      end
      if (cmd.load_out) begin
         out_status_ff   <= status_ff;
         out_accepted_ff <= accepted_ff;
         out_rejected_ff <= rejected_ff;
         out_quality_ff  <= (den_ff == '0) ? QUAL_W'(PCT_SCALE) : quot_ff;
      end
   end

   assign status_out   = out_status_ff;
   assign accepted_out = out_accepted_ff;
   assign rejected_out = out_rejected_ff;
   assign quality_out  = out_quality_ff;

endmodule

### rtl/swrc_ctrl.sv
// Controller: sequences capture, check, divide and output load for each beat.
module swrc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output swrc_pkg::cmd_type cmd,
   input  swrc_pkg::sts_type sts
);
   import swrc_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign out_free  = !out_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      out_valid_in  = out_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            cmd.start_div = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### rtl/sliding_window_replay_check.sv
// Top level of the 64-entry anti-replay sliding-window check.
//
// Usage: one sequence number enters per request beat on req_bus; each one
// produces exactly one response beat on rsp_bus carrying the accept/reject
// status, the wrapping accepted and rejected counts after the update, and
// the accept percentage floor(accepted*100/(accepted+rejected)), 100 when
// both counts are zero. The first number after reset seeds the window.
// Between the request beat and the response becoming valid, each item goes
// through the window check, multiply, 7 restoring divide steps, output load.
// The 7-step serial divider runs once per item and the request side is
// ready only between items, so no new item is taken before the last is done.
// The response sits in an output register, so the next request is taken
// while a finished response still waits; if the receiver keeps stalling,
// the following item waits in its load step until the register frees.
// Reset (synchronous, active high) clears the window, the seed flag, both
// counters and any pending response; no clearing pass is needed.
module sliding_window_replay_check (
   input logic        clock,
   input logic        reset,
   swrc_req_if.sink   req_bus,
   swrc_rsp_if.source rsp_bus
);
   import swrc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   swrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   swrc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .seq_in       (req_bus.sequence_req),
      .status_out   (rsp_bus.status),
      .accepted_out (rsp_bus.accepted_count),
      .rejected_out (rsp_bus.rejected_count),
      .quality_out  (rsp_bus.accept_pct)
   );

   // A taken request closes the request side while the item is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request side still ready after accepting a beat");

   // Quality is a percentage
   a_quality_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.accept_pct <= QUAL_W'(PCT_SCALE)))
      else $error("accept percentage above 100");

   // No rejects counted means full quality
   a_quality_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.rejected_count == '0) && (rsp_bus.accepted_count != '0))
      |-> (rsp_bus.accept_pct == QUAL_W'(PCT_SCALE)))
      else $error("accept percentage not 100 with zero rejects");

endmodule
